[src/vmbr_pkg.sv]
// ----------------------------------------------------------------------------
// vmbr_pkg
// Shared types and constants for the legacy virtio-mmio block register file.
// ----------------------------------------------------------------------------
package vmbr_pkg;

    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;

    localparam logic CFG_CAPACITY   = 1'b0;
    localparam logic CFG_CARD_READY = 1'b1;

    localparam logic [11:0] OFF_MAGIC      = 12'h000;
    localparam logic [11:0] OFF_VERSION    = 12'h004;
    localparam logic [11:0] OFF_DEVICE_ID  = 12'h008;
    localparam logic [11:0] OFF_VENDOR_ID  = 12'h00C;
    localparam logic [11:0] OFF_FEATURES   = 12'h010;
    localparam logic [11:0] OFF_PAGE_SIZE  = 12'h028;
    localparam logic [11:0] OFF_QUEUE_MAX  = 12'h034;
    localparam logic [11:0] OFF_QUEUE_NUM  = 12'h038;
    localparam logic [11:0] OFF_QUEUE_ALIGN = 12'h03C;
    localparam logic [11:0] OFF_QUEUE_PFN  = 12'h040;
    localparam logic [11:0] OFF_NOTIFY     = 12'h050;
    localparam logic [11:0] OFF_IRQ_STATUS = 12'h060;
    localparam logic [11:0] OFF_IRQ_ACK    = 12'h064;
    localparam logic [11:0] OFF_STATUS     = 12'h070;
    localparam logic [11:0] OFF_CFG_START  = 12'h100;

    localparam logic [31:0] MAGIC_WORD        = 32'h7472_6976;
    localparam logic [31:0] VERSION_WORD      = 32'd1;
    localparam logic [31:0] BLOCK_DEV_ID      = 32'd2;
    localparam logic [31:0] VENDOR_WORD       = 32'h5034_5052;
    localparam logic [31:0] MAX_QUEUE_ENTRIES = 32'd128;
    localparam logic [31:0] DEFAULT_ALIGN_M1  = 32'd4095;

    typedef struct packed {
        logic [31:0] frame;
        logic [31:0] page;
        logic [31:0] size;
        logic [31:0] align;
    } geometry_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
        logic        notify;
        logic        live;
        logic        rst;
    } step_flags_t;

endpackage

[src/vmbr_regs.sv]
// ----------------------------------------------------------------------------
// vmbr_regs
// Register state, read decode and write side effects for one transaction.
// ----------------------------------------------------------------------------
module vmbr_regs
    import vmbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        opcode,
    input  logic [11:0]       reg_offset,
    input  logic [31:0]       write_value,
    input  logic [2:0]        access_width,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data,
    output step_flags_t       step,
    output geometry_t         geom
);

    logic [63:0] capacity_reg;
    logic        card_ready_reg;
    logic [31:0] driver_status_reg, driver_status_next;
    logic [31:0] page_size_reg, page_size_next;
    logic [31:0] ring_size_reg, ring_size_next;
    logic [31:0] ring_align_reg, ring_align_next;
    logic [31:0] ring_frame_reg, ring_frame_next;
    logic [31:0] irq_status_reg, irq_status_next;
    logic        ring_live_reg, ring_live_next;
    logic        irq_asserted_reg, irq_asserted_next;

    logic [31:0] cfg_word;
    logic [31:0] reg_word;
    logic [31:0] ack_status;
    logic [11:0] cfg_base;
    logic [2:0]  cfg_width;
    logic        kick;
    logic        ring_rst;

    always_comb
    begin
        logic [12:0] byte_idx;
        cfg_base  = reg_offset - OFF_CFG_START;
        cfg_width = (access_width > 3'd4) ? 3'd4 : access_width;
        cfg_word  = '0;
        for (int i = 0; i < 4; i++)
        begin
            byte_idx = {1'b0, cfg_base} + 13'(i);
            if ((3'(i) < cfg_width) && (byte_idx < 13'd8))
            begin
                cfg_word[8*i +: 8] = capacity_reg[{byte_idx[2:0], 3'b000} +: 8];
            end
        end
    end

    always_comb
    begin
        unique case (reg_offset)
            OFF_MAGIC:      reg_word = MAGIC_WORD;
            OFF_VERSION:    reg_word = VERSION_WORD;
            OFF_DEVICE_ID:  reg_word = BLOCK_DEV_ID;
            OFF_VENDOR_ID:  reg_word = VENDOR_WORD;
            OFF_FEATURES:   reg_word = '0;
            OFF_QUEUE_MAX:  reg_word = MAX_QUEUE_ENTRIES;
            OFF_QUEUE_PFN:  reg_word = ring_frame_reg;
            OFF_IRQ_STATUS: reg_word = irq_status_reg;
            OFF_STATUS:     reg_word = driver_status_reg;
            default:        reg_word = '0;
        endcase
    end

    assign ack_status = irq_status_reg & ~write_value;

    always_comb
    begin
        driver_status_next = driver_status_reg;
        page_size_next     = page_size_reg;
        ring_size_next     = ring_size_reg;
        ring_align_next    = ring_align_reg;
        ring_frame_next    = ring_frame_reg;
        irq_status_next    = irq_status_reg;
        ring_live_next     = ring_live_reg;
        irq_asserted_next  = irq_asserted_reg;
        kick               = 1'b0;
        ring_rst           = 1'b0;
        step.rdata         = '0;
        unique case (opcode)
            OP_READ:
            begin
                step.rdata = (reg_offset >= OFF_CFG_START) ? cfg_word : reg_word;
            end
            OP_WRITE:
            begin
                unique case (reg_offset)
                    OFF_PAGE_SIZE:   page_size_next  = write_value;
                    OFF_QUEUE_NUM:   ring_size_next  = write_value;
                    OFF_QUEUE_ALIGN: ring_align_next = write_value;
                    OFF_QUEUE_PFN:
                    begin
                        ring_frame_next = write_value;
                        ring_live_next  = (write_value != '0) && (ring_size_reg != '0)
                                          && (page_size_reg != '0) && card_ready_reg;
                        ring_rst        = 1'b1;
                    end
                    OFF_NOTIFY:      kick = 1'b1;
                    OFF_IRQ_ACK:
                    begin
                        irq_status_next = ack_status;
                        if (ack_status == '0)
                        begin
                            irq_asserted_next = 1'b0;
                        end
                    end
                    OFF_STATUS:
                    begin
                        driver_status_next = write_value;
                        if (write_value == '0)
                        begin
                            ring_live_next    = 1'b0;
                            irq_status_next   = '0;
                            irq_asserted_next = 1'b0;
                            ring_rst          = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_COMPLETE:
            begin
                irq_status_next   = irq_status_reg | 32'd1;
                irq_asserted_next = 1'b1;
            end
            default: ;
        endcase
        step.irq    = irq_asserted_next;
        step.notify = kick;
        step.live   = ring_live_next;
        step.rst    = ring_rst;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg      <= '0;
            card_ready_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPACITY:   capacity_reg   <= cfg_data;
                CFG_CARD_READY: card_ready_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            driver_status_reg <= '0;
            page_size_reg     <= '0;
            ring_size_reg     <= '0;
            ring_align_reg    <= '0;
            ring_frame_reg    <= '0;
            irq_status_reg    <= '0;
            ring_live_reg     <= 1'b0;
            irq_asserted_reg  <= 1'b0;
        end
        else if (accept)
        begin
            driver_status_reg <= driver_status_next;
            page_size_reg     <= page_size_next;
            ring_size_reg     <= ring_size_next;
            ring_align_reg    <= ring_align_next;
            ring_frame_reg    <= ring_frame_next;
            irq_status_reg    <= irq_status_next;
            ring_live_reg     <= ring_live_next;
            irq_asserted_reg  <= irq_asserted_next;
        end
    end

    assign geom.frame = ring_frame_reg;
    assign geom.page  = page_size_reg;
    assign geom.size  = ring_size_reg;
    assign geom.align = ring_align_reg;

endmodule

[src/vmbr_ring_calc.sv]
// ----------------------------------------------------------------------------
// vmbr_ring_calc
// Two-stage ring base address calculation: multiply, then add and align.
// ----------------------------------------------------------------------------
module vmbr_ring_calc
    import vmbr_pkg::*;
(
    input  logic        clk,
    input  logic        load_mul,
    input  logic        load_sum,
    input  geometry_t   geom,
    output logic [31:0] desc_base,
    output logic [31:0] avail_base,
    output logic [31:0] used_base
);

    logic [31:0] prod_reg;
    logic [31:0] ring_bytes_reg;
    logic [31:0] tail_bytes_reg;
    logic [31:0] align_m1_reg;
    logic [31:0] align_m1;
    logic [31:0] round_sum;
    logic [31:0] desc_reg;
    logic [31:0] avail_reg;
    logic [31:0] used_reg;

    assign align_m1 = (geom.align == '0) ? DEFAULT_ALIGN_M1 : (geom.align - 32'd1);

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            prod_reg       <= geom.frame * geom.page;
            ring_bytes_reg <= {geom.size[27:0], 4'b0000};
            tail_bytes_reg <= {geom.size[27:0], 4'b0000} + {geom.size[30:0], 1'b0}
                              + 32'd6;
            align_m1_reg   <= align_m1;
        end
    end

    assign round_sum = prod_reg + tail_bytes_reg + align_m1_reg;

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            desc_reg  <= prod_reg;
            avail_reg <= prod_reg + ring_bytes_reg;
            used_reg  <= round_sum & ~align_m1_reg;
        end
    end

    assign desc_base  = desc_reg;
    assign avail_base = avail_reg;
    assign used_base  = used_reg;

endmodule

[src/virtio_mmio_block_register_front_end.sv]
// Pipeline: an accepted result passes through s1_reg, s2_reg and s3_reg to the
//   outputs; an output stall can hold it in any of them.
// Throughput: one transaction per cycle while out_stall is low; the ring base
//   multiply and add/align each own a pipeline stage behind the register file.
// Reset: rst_n clears all device registers, configuration and pipeline valids.
// ----------------------------------------------------------------------------
// virtio_mmio_block_register_front_end
// Legacy virtio-mmio block device register file with ring base outputs.
// ----------------------------------------------------------------------------
module virtio_mmio_block_register_front_end
    import vmbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [11:0] reg_offset,
    input  logic [31:0] write_value,
    input  logic [2:0]  access_width,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        irq_line,
    output logic        notify,
    output logic        queue_live,
    output logic        ring_reset,
    output logic [31:0] desc_base,
    output logic [31:0] avail_base,
    output logic [31:0] used_base
);

    step_flags_t step;
    geometry_t   geom;
    step_flags_t s1_reg, s2_reg, s3_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        rdy1, rdy2, rdy3;
    logic        accept;

    assign rdy3     = !v3_reg || !out_stall;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;
    assign accept   = in_valid && rdy1;

    vmbr_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .opcode       (opcode),
        .reg_offset   (reg_offset),
        .write_value  (write_value),
        .access_width (access_width),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step         (step),
        .geom         (geom)
    );

    vmbr_ring_calc u_ring_calc (
        .clk        (clk),
        .load_mul   (v1_reg && rdy2),
        .load_sum   (v2_reg && rdy3),
        .geom       (geom),
        .desc_base  (desc_base),
        .avail_base (avail_base),
        .used_base  (used_base)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= step;
        end
        if (v1_reg && rdy2)
        begin
            s2_reg <= s1_reg;
        end
        if (v2_reg && rdy3)
        begin
            s3_reg <= s2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign read_data  = s3_reg.rdata;
    assign irq_line   = s3_reg.irq;
    assign notify     = s3_reg.notify;
    assign queue_live = s3_reg.live;
    assign ring_reset = s3_reg.rst;

    // notify comes only from a write, which returns no read data
    a_notify_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && notify) |-> (read_data == '0))
        else $error("notify with nonzero read data");

    a_notify_rst_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(notify && ring_reset))
        else $error("notify and ring_reset in one transaction");

    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (!v1_reg || !v2_reg || !v3_reg || !out_stall))
        else $error("transaction accepted into a full pipeline");

endmodule
